FILE: src/bsnt_pkg.sv
// ----------------------------------------------------------------------------
// bsnt_pkg
// Shared types, constants and helpers of the binary search name table.
// ----------------------------------------------------------------------------
package bsnt_pkg;

	localparam int NameWords         = 7;
	localparam int WordBytes         = 7;
	localparam int WordW             = 56;
	localparam int KeyW              = NameWords * WordW;
	localparam int EntryCountW       = 11;
	localparam int ComparisonsW      = 32;
	localparam int TableDepthDefault = 1024;
	localparam int NameBytesDefault  = 49;

	localparam logic ModeAppend = 1'b0;
	localparam logic ModeSearch = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [WordW-1:0] name_chars_0;
		logic [WordW-1:0] name_chars_1;
		logic [WordW-1:0] name_chars_2;
		logic [WordW-1:0] name_chars_3;
		logic [WordW-1:0] name_chars_4;
		logic [WordW-1:0] name_chars_5;
		logic [WordW-1:0] name_chars_6;
	} bsnt_item_t;

	typedef struct packed {
		logic                    found;
		logic [ComparisonsW-1:0] comparisons;
		logic                    table_full;
		logic [EntryCountW-1:0]  entry_count;
	} bsnt_result_t;

	typedef struct packed {
		logic load;
		logic probe;
	} bsnt_cmd_t;

	typedef struct packed {
		logic go_probe;
		logic stop;
	} bsnt_sts_t;

	function automatic logic [WordW-1:0] limit_word(input logic [WordW-1:0] v,
			input int word_idx, input int name_bytes);
		logic [WordW-1:0] mask;
		mask = '0;
		for (int k = 0; k < WordBytes; k++) begin
			if (word_idx * WordBytes + k < name_bytes)
				mask[WordW-1-8*k -: 8] = 8'hFF;
		end
		return v & mask;
	endfunction

	function automatic logic [KeyW-1:0] build_key(input bsnt_item_t item,
			input int name_bytes);
		return {limit_word(item.name_chars_0, 0, name_bytes),
			limit_word(item.name_chars_1, 1, name_bytes),
			limit_word(item.name_chars_2, 2, name_bytes),
			limit_word(item.name_chars_3, 3, name_bytes),
			limit_word(item.name_chars_4, 4, name_bytes),
			limit_word(item.name_chars_5, 5, name_bytes),
			limit_word(item.name_chars_6, 6, name_bytes)};
	endfunction

endpackage

FILE: src/binary_search_name_table.sv
// ----------------------------------------------------------------------------
// binary_search_name_table
// Name table with append and binary search over the stored names.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload         Direction
// command   start, busy      item            in
// result    done (strobe)    result          out
//
// A result beat comes in the cycle after its command beat for an append; for a search
// the P probe states lie between the two, P the probe count (0 on an empty table, at most
// floor(log2(entries)) + 1), one probe per cycle through the registered memory read.
// busy falls after the result beat; a new command beat is taken only in idle.
// done marks the result for one cycle; the receiver cannot stall it.
// Reset clears the entry count and the probe counter; no memory clear pass.
// ----------------------------------------------------------------------------
module binary_search_name_table #(
	parameter int TABLE_DEPTH = bsnt_pkg::TableDepthDefault,
	parameter int NAME_BYTES  = bsnt_pkg::NameBytesDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  bsnt_pkg::bsnt_item_t   item,
	output logic                   done,
	output bsnt_pkg::bsnt_result_t result
);

	bsnt_pkg::bsnt_cmd_t cmd;
	bsnt_pkg::bsnt_sts_t sts;

	bsnt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bsnt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NAME_BYTES  (NAME_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.sts    (sts),
		.result (result)
	);

endmodule

FILE: src/bsnt_ctrl.sv
// ----------------------------------------------------------------------------
// bsnt_ctrl
// Sequencer: takes a command beat, steps the probe loop, strobes the result.
// ----------------------------------------------------------------------------
module bsnt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bsnt_pkg::bsnt_sts_t sts,
	output bsnt_pkg::bsnt_cmd_t cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StProbe = 2'd1;
	localparam logic [1:0] StDone  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.probe = 1'b0;
		case (state_q)
			StIdle: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.go_probe ? StProbe : StDone;
				end
			end
			StProbe: begin
				cmd.probe = 1'b1;
				if (sts.stop)
					state_d = StDone;
			end
			StDone: begin
				state_d = StIdle;
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= StIdle;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != StIdle);
	assign done = (state_q == StDone);

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy) else $error("busy not raised after command beat");
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe && sts.stop) |=> done) else $error("result missing after last probe");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result beat");

endmodule

FILE: src/bsnt_dp.sv
// ----------------------------------------------------------------------------
// bsnt_dp
// Datapath: name memory, entry count, probe bounds, key compare, counters.
// ----------------------------------------------------------------------------
module bsnt_dp #(
	parameter int TABLE_DEPTH = bsnt_pkg::TableDepthDefault,
	parameter int NAME_BYTES  = bsnt_pkg::NameBytesDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bsnt_pkg::bsnt_cmd_t    cmd,
	input  bsnt_pkg::bsnt_item_t   item,
	output bsnt_pkg::bsnt_sts_t    sts,
	output bsnt_pkg::bsnt_result_t result
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int KW = bsnt_pkg::KeyW;
	localparam int PW = bsnt_pkg::ComparisonsW;

	logic [KW-1:0] mem_q [TABLE_DEPTH];
	logic [KW-1:0] rdata_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] key_in;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi1_q;
	logic [CW-1:0] mid_q;
	logic [CW-1:0] lo_d;
	logic [CW-1:0] hi1_d;
	logic [CW-1:0] mid_d;
	logic [CW:0]   mid_sum;
	logic [PW-1:0] probe_q;
	logic          found_q;
	logic          full_q;
	logic          is_full;
	logic          is_search;
	logic          wr_en;
	logic          hit;
	logic          key_gt;

	assign key_in    = bsnt_pkg::build_key(item, NAME_BYTES);
	assign is_full   = (count_q == CW'(TABLE_DEPTH));
	assign is_search = (item.mode == bsnt_pkg::ModeSearch);
	assign wr_en     = cmd.load && !is_search && !is_full;
	assign hit       = (key_q == rdata_q);
	assign key_gt    = (key_q > rdata_q);

	always_comb begin
		lo_d  = lo_q;
		hi1_d = hi1_q;
		if (cmd.load) begin
			lo_d  = '0;
			hi1_d = count_q;
		end else if (cmd.probe) begin
			if (key_gt)
				lo_d = mid_q + CW'(1);
			else
				hi1_d = mid_q;
		end
	end

	assign mid_sum = ({1'b0, lo_d} + {1'b0, hi1_d} - (CW+1)'(1)) >> 1;
	assign mid_d   = mid_sum[CW-1:0];

	assign sts.go_probe = is_search && (count_q != '0);
	assign sts.stop     = hit || !(lo_d < hi1_d);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[count_q[AW-1:0]] <= key_in;
		rdata_q <= mem_q[mid_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			key_q <= key_in;
		lo_q  <= lo_d;
		hi1_q <= hi1_d;
		mid_q <= mid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			probe_q <= '0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				full_q  <= !is_search && is_full;
				if (wr_en)
					count_q <= count_q + CW'(1);
			end
			if (cmd.probe) begin
				if (probe_q != '1)
					probe_q <= probe_q + PW'(1);
				if (hit)
					found_q <= 1'b1;
			end
		end
	end

	assign result.found       = found_q;
	assign result.comparisons = probe_q;
	assign result.table_full  = full_q;
	assign result.entry_count = bsnt_pkg::EntryCountW'(count_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("entry count beyond table depth");
	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (lo_q < hi1_q) && (mid_q < count_q))
		else $error("probe outside stored entries");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_search_name_table. A table of directed rows
// covers the empty table, zero and all-ones names, names that differ after a
// zero byte, an out-of-order entry and the last name byte. Random beats then
// fill the table with mostly ascending names mixed with duplicates, stray
// names and searches for stored, near-miss and unrelated names, until the
// table is full and appends bounce. Every result is checked field by field
// against the row's typed result or a behavioral copy of the table in the bench.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsnt_pkg::*;

	localparam int TableDepth  = TableDepthDefault;
	localparam int NameBytes   = NameBytesDefault;
	localparam int RandomBeats = 1500;
	localparam int QuietLimit  = 1000;

	localparam logic [KeyW-1:0] NoName   = '0;
	localparam logic [KeyW-1:0] FullName = '1;
	localparam logic [KeyW-1:0] AbName   = {56'h41420000000000, 336'h0};
	localparam logic [KeyW-1:0] AbxName  = {56'h41420058000000, 336'h0};
	localparam logic [KeyW-1:0] AbcName  = {56'h41424300000000, 336'h0};
	localparam logic [KeyW-1:0] AaName   = {56'h41410000000000, 336'h0};
	localparam logic [KeyW-1:0] AbdLong  = {56'h41424400000000, 280'h0, 56'h1};
	localparam logic [KeyW-1:0] LastByte = {336'h0, 56'h1};
	localparam logic [KeyW-1:0] AbeName  = {56'h41424500000000, 336'h0};

	typedef struct packed {
		logic             mode;
		logic [KeyW-1:0]  name;
		bit               typed;
		bsnt_result_t     want;
	} directed_row_t;

	localparam directed_row_t DirectedRows [18] = '{
		'{ModeSearch, NoName,   1'b1, {1'b0, 32'd0, 1'b0, 11'd0}},
		'{ModeSearch, FullName, 1'b1, {1'b0, 32'd0, 1'b0, 11'd0}},
		'{ModeAppend, NoName,   1'b1, {1'b0, 32'd0, 1'b0, 11'd1}},
		'{ModeSearch, NoName,   1'b1, {1'b1, 32'd1, 1'b0, 11'd1}},
		'{ModeSearch, FullName, 1'b1, {1'b0, 32'd2, 1'b0, 11'd1}},
		'{ModeAppend, AbName,   1'b1, {1'b0, 32'd2, 1'b0, 11'd2}},
		'{ModeAppend, AbxName,  1'b1, {1'b0, 32'd2, 1'b0, 11'd3}},
		'{ModeSearch, AbName,   1'b0, '0},
		'{ModeSearch, AbxName,  1'b0, '0},
		'{ModeAppend, AbcName,  1'b0, '0},
		'{ModeAppend, AaName,   1'b0, '0},
		'{ModeSearch, AaName,   1'b0, '0},
		'{ModeSearch, AbcName,  1'b0, '0},
		'{ModeAppend, AbdLong,  1'b0, '0},
		'{ModeSearch, AbdLong,  1'b0, '0},
		'{ModeSearch, LastByte, 1'b0, '0},
		'{ModeSearch, FullName, 1'b0, '0},
		'{ModeAppend, AbeName,  1'b0, '0}
	};

	logic         clk;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	bsnt_item_t   item = '0;
	logic         done;
	bsnt_result_t result;

	logic [KeyW-1:0]         name_mem [TableDepth];
	int                      names_held = 0;
	logic [ComparisonsW-1:0] probe_count = '0;
	bsnt_result_t            pending_results [$];
	logic [KeyW-1:0]         last_sorted = AbeName;
	bit                      idle_on = 1'b1;
	bit                      failed = 1'b0;
	int                      quiet_cycles = 0;

	binary_search_name_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [KeyW-1:0] clip_name(input logic [KeyW-1:0] raw);
		for (int i = NameBytes; i < NameWords * WordBytes; i++)
			raw[KeyW-1-8*i -: 8] = 8'h00;
		return raw;
	endfunction

	function automatic bsnt_result_t lookup_or_store(input bsnt_item_t it);
		logic [KeyW-1:0] key;
		bsnt_result_t    r;
		int              lo;
		int              hi;
		int              mid;
		key = clip_name({it.name_chars_0, it.name_chars_1, it.name_chars_2,
			it.name_chars_3, it.name_chars_4, it.name_chars_5, it.name_chars_6});
		r = '0;
		if (it.mode == ModeAppend) begin
			if (names_held >= TableDepth) begin
				r.table_full = 1'b1;
			end else begin
				name_mem[names_held] = key;
				names_held++;
			end
		end else begin
			lo = 0;
			hi = names_held - 1;
			while (lo <= hi && !r.found) begin
				mid = (lo + hi) / 2;
				if (probe_count != '1)
					probe_count++;
				if (key == name_mem[mid])
					r.found = 1'b1;
				else if (key > name_mem[mid])
					lo = mid + 1;
				else
					hi = mid - 1;
			end
		end
		r.comparisons = probe_count;
		r.entry_count = names_held[EntryCountW-1:0];
		return r;
	endfunction

	function automatic logic [KeyW-1:0] rand_key();
		logic [13*32-1:0] raw;
		for (int i = 0; i < 13; i++)
			raw[32*i +: 32] = $urandom;
		return raw[KeyW-1:0];
	endfunction

	function automatic logic [KeyW-1:0] word_name();
		logic [KeyW-1:0] k;
		int              len;
		k = '0;
		len = $urandom_range(NameBytes, 0);
		for (int i = 0; i < len; i++)
			k[KeyW-1-8*i -: 8] = 8'($urandom_range(8'h7a, 8'h41));
		return k;
	endfunction

	function automatic logic [KeyW-1:0] next_sorted(input logic [KeyW-1:0] prev);
		logic [KeyW-1:0] nxt;
		logic [7:0]      v;
		int              b;
		bit              pad;
		nxt = prev;
		b = $urandom_range(NameBytes - 1, 0);
		while (b > 0 && nxt[KeyW-1-8*b -: 8] == 8'hFF)
			b--;
		v = nxt[KeyW-1-8*b -: 8];
		nxt[KeyW-1-8*b -: 8] = v + ((v >= 8'hFC) ? 8'd1 : 8'($urandom_range(4, 1)));
		pad = ($urandom_range(3) == 0);
		for (int i = b + 1; i < NameBytes; i++)
			nxt[KeyW-1-8*i -: 8] = pad ? 8'h00 : 8'($urandom_range(255));
		return nxt;
	endfunction

	function automatic logic [KeyW-1:0] search_name();
		logic [KeyW-1:0] k;
		int              pick;
		int              flip;
		pick = $urandom_range(99);
		if (names_held > 0 && pick < 45) begin
			k = name_mem[$urandom_range(names_held - 1, 0)];
		end else if (names_held > 0 && pick < 65) begin
			k = name_mem[$urandom_range(names_held - 1, 0)];
			flip = $urandom_range(KeyW - 1, 0);
			k[flip] = ~k[flip];
		end else if (pick < 80) begin
			k = word_name();
		end else if (pick < 90) begin
			k = rand_key();
		end else begin
			k = $urandom_range(1) ? FullName : NoName;
		end
		return k;
	endfunction

	task automatic send_beat(input logic mode, input logic [KeyW-1:0] name,
			input bit typed, input bsnt_result_t want);
		bsnt_result_t model_out;
		int           gap;
		gap = (idle_on && $urandom_range(99) < 19) ? $urandom_range(14, 1) : 0;
		repeat (gap) begin
			start <= 1'b0;
			item <= bsnt_item_t'({1'($urandom_range(1)), rand_key()});
			@(posedge clk);
		end
		start <= 1'b1;
		item <= bsnt_item_t'({mode, name});
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model_out = lookup_or_store(bsnt_item_t'({mode, name}));
		pending_results.push_back(typed ? want : model_out);
	endtask

	initial begin : stimulus
		logic            mode;
		logic [KeyW-1:0] name;
		bit              full;
		int              kind;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DirectedRows[i])
			send_beat(DirectedRows[i].mode, DirectedRows[i].name,
				DirectedRows[i].typed, DirectedRows[i].want);
		for (int n = 0; n < RandomBeats; n++) begin
			idle_on = !(n >= 400 && n < 700);
			full = (names_held >= TableDepth);
			if ($urandom_range(99) < (full ? 30 : 75)) begin
				mode = ModeAppend;
				kind = $urandom_range(99);
				if (kind < 92) begin
					name = next_sorted(last_sorted);
					last_sorted = name;
				end else if (kind < 95) begin
					name = last_sorted;
				end else begin
					name = $urandom_range(1) ? word_name() : rand_key();
				end
			end else begin
				mode = ModeSearch;
				name = search_name();
			end
			send_beat(mode, name, 1'b0, '0);
		end
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin : check_results
		bsnt_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, got %p", $time, result);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (result.found !== want.found) begin
					$display("%0t ns: found expected %0d, got %0d",
						$time, want.found, result.found);
					failed = 1'b1;
				end
				if (result.comparisons !== want.comparisons) begin
					$display("%0t ns: comparisons expected %0d, got %0d",
						$time, want.comparisons, result.comparisons);
					failed = 1'b1;
				end
				if (result.table_full !== want.table_full) begin
					$display("%0t ns: table_full expected %0d, got %0d",
						$time, want.table_full, result.table_full);
					failed = 1'b1;
				end
				if (result.entry_count !== want.entry_count) begin
					$display("%0t ns: entry_count expected %0d, got %0d",
						$time, want.entry_count, result.entry_count);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
